>>> hw/rtl/pngc_pkg.sv
// Shared types, codes and helpers for the PNG chunk stream checker.
// Self-contained; imported by every module of the block.
`timescale 1ns / 1ps

package pngc_pkg;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_ERROR  = 2'd3
  } pngc_kind_e;

  typedef enum logic [3:0] {
    ERR_SIGNATURE  = 4'd0,
    ERR_LENGTH     = 4'd1,
    ERR_CRC        = 4'd2,
    ERR_IHDR       = 4'd3,
    ERR_NO_IHDR    = 4'd4,
    ERR_EMPTY_IDAT = 4'd5,
    ERR_IEND       = 4'd6,
    ERR_TRUNCATED  = 4'd7,
    ERR_NO_DATA    = 4'd8
  } pngc_err_e;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;
  localparam logic [31:0] TYPE_IHDR  = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT  = 32'h49444154;
  localparam logic [31:0] TYPE_IEND  = 32'h49454E44;
  localparam logic [30:0] IHDR_LEN   = 31'd13;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } pngc_in_t;

  typedef struct packed {
    pngc_kind_e  kind;
    logic [7:0]  data_byte;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  sample_depth;
    logic [2:0]  color_type;
    pngc_err_e   error_code;
  } pngc_out_t;

  // parser result request towards the output stage
  typedef struct packed {
    logic      valid;
    pngc_out_t item;
  } pngc_res_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = 8'd137;
      3'd1: v = 8'd80;
      3'd2: v = 8'd78;
      3'd3: v = 8'd71;
      3'd4: v = 8'd13;
      3'd5: v = 8'd10;
      3'd6: v = 8'd26;
      3'd7: v = 8'd10;
    endcase
    return v;
  endfunction

  function automatic logic color_ok(input logic [7:0] c);
    return (c == 8'd0) || (c == 8'd2) || (c == 8'd3) || (c == 8'd4) || (c == 8'd6);
  endfunction

endpackage

>>> hw/rtl/png_chunk_stream_checker_core.sv
// PNG chunk stream checker: signature, chunk framing, CRC-32 and IHDR/IDAT/IEND rules.
// Instantiates pngc_parser and pngc_out_stage; depends on pngc_pkg.
//
// Input channel: one file byte per request (in_data_i.file_byte), with
// end_of_file marking the last byte. Output channel: at most one result per
// input byte: an IDAT payload byte, the parsed header, file accepted, or an
// error with its code.
// Each byte is processed in the cycle it is accepted; its result is registered
// and shows on out_valid_o in the next cycle. One byte is taken per cycle, unless
// a result is stalled, limited by the byte-wide CRC update and the 31-bit chunk
// counter compare. After an error or acceptance the block keeps taking bytes but
// drops them and gives no further result until reset.
// Reset (rst_ni low, asynchronous) returns the parser to the signature phase
// and empties the output register; no clearing time is needed.
// When the receiver stalls with a result pending, in_stall_o rises in the
// same cycle; a result leaving while a new byte enters is handled without a
// bubble.
`timescale 1ns / 1ps

module png_chunk_stream_checker_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pngc_pkg::pngc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pngc_pkg::pngc_out_t out_data_o
);
  import pngc_pkg::*;

  logic      fire;
  logic      full_stall;
  pngc_res_t res;

  assign in_stall_o = full_stall;
  assign fire       = in_valid_i && !full_stall;

  pngc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .in_i   (in_data_i),
    .res_o  (res)
  );

  pngc_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (fire),
    .res_i        (res),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .full_stall_o (full_stall)
  );

  // input is only held back by a pending, stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a pending result");

  a_header_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_HEADER)
      |-> (out_data_o.image_width != '0 && out_data_o.image_height != '0))
    else $error("header result with zero dimension");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_ERROR) |-> (out_data_o.error_code <= ERR_NO_DATA))
    else $error("error code out of range");

  // a byte accepted into a free slot with a result must show it next cycle
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.valid) |=> out_valid_o)
    else $error("result lost at output register");

endmodule

>>> hw/rtl/pngc_parser.sv
// Chunk parser: phase register, counters, CRC and IHDR capture, one byte per cycle while fire_i is set.
// Depends on pngc_pkg.
`timescale 1ns / 1ps

module pngc_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  pngc_pkg::pngc_in_t in_i,
  output pngc_pkg::pngc_res_t res_o
);
  import pngc_pkg::*;

  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [30:0] count_q, count_d;
  logic [30:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] stored_q, stored_d;
  logic        hdr_seen_q, hdr_seen_d;
  logic        pay_seen_q, pay_seen_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [7:0]  depth_q, depth_d;
  logic [7:0]  color_q, color_d;
  logic        halted_q;

  logic [7:0]  b;
  logic        eof;
  logic [30:0] count_inc;
  logic        err_v;
  pngc_err_e   err_c;
  logic        accept, hdr, data;

  assign b         = in_i.file_byte;
  assign eof       = in_i.end_of_file;
  assign count_inc = count_q + 31'd1;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    len_d      = len_q;
    type_d     = type_q;
    crc_d      = crc_q;
    stored_d   = stored_q;
    hdr_seen_d = hdr_seen_q;
    pay_seen_d = pay_seen_q;
    width_d    = width_q;
    height_d   = height_q;
    depth_d    = depth_q;
    color_d    = color_q;
    err_v      = 1'b0;
    err_c      = ERR_SIGNATURE;
    accept     = 1'b0;
    hdr        = 1'b0;
    data       = 1'b0;

    unique case (phase_q)
      PH_SIG: begin
        if (b != sig_byte(count_q[2:0])) begin
          err_v = 1'b1;
          err_c = ERR_SIGNATURE;
        end else if (count_q[2:0] == 3'd7) begin
          phase_d = PH_LEN;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      PH_LEN: begin
        if (count_q == '0 && b[7]) begin
          err_v = 1'b1;
          err_c = ERR_LENGTH;
        end else begin
          len_d = {len_q[22:0], b};
          if (count_q[1:0] == 2'd3) begin
            phase_d = PH_TYPE;
            count_d = '0;
            type_d  = '0;
            crc_d   = CRC_PRESET;
          end else begin
            count_d = count_inc;
          end
        end
      end
      PH_TYPE: begin
        type_d = {type_q[23:0], b};
        crc_d  = crc_byte(crc_q, b);
        if (count_q[1:0] == 2'd3) begin
          count_d  = '0;
          stored_d = '0;
          phase_d  = (len_q != '0) ? PH_DATA : PH_CRC;
        end else begin
          count_d = count_inc;
        end
      end
      PH_DATA: begin
        crc_d = crc_byte(crc_q, b);
        if (type_q == TYPE_IHDR) begin
          if (count_q < 31'd4) width_d = {width_q[23:0], b};
          else if (count_q < 31'd8) height_d = {height_q[23:0], b};
          else if (count_q == 31'd8) depth_d = b;
          else if (count_q == 31'd9) color_d = b;
        end else if (type_q == TYPE_IDAT && hdr_seen_q) begin
          data = 1'b1;
        end
        if (count_inc == len_q) begin
          phase_d = PH_CRC;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      PH_CRC: begin
        stored_d = {stored_q[23:0], b};
        if (count_q[1:0] == 2'd3) begin
          phase_d = PH_LEN;
          count_d = '0;
          len_d   = '0;
          // checks in fixed order at the last CRC byte
          if (~crc_q != stored_d) begin
            err_v = 1'b1;
            err_c = ERR_CRC;
          end else if (type_q == TYPE_IHDR) begin
            if (len_q != IHDR_LEN || hdr_seen_q || width_q == '0 || height_q == '0
                || !color_ok(color_q)) begin
              err_v = 1'b1;
              err_c = ERR_IHDR;
            end else begin
              hdr_seen_d = 1'b1;
              hdr        = 1'b1;
            end
          end else if (!hdr_seen_q) begin
            err_v = 1'b1;
            err_c = ERR_NO_IHDR;
          end else if (type_q == TYPE_IDAT) begin
            if (len_q == '0) begin
              err_v = 1'b1;
              err_c = ERR_EMPTY_IDAT;
            end else begin
              pay_seen_d = 1'b1;
            end
          end else if (type_q == TYPE_IEND) begin
            if (len_q != '0 || !eof) begin
              err_v = 1'b1;
              err_c = ERR_IEND;
            end else if (!pay_seen_q) begin
              err_v = 1'b1;
              err_c = ERR_NO_DATA;
            end else begin
              accept = 1'b1;
            end
          end
        end else begin
          count_d = count_inc;
        end
      end
      default: begin
        phase_d = PH_SIG;
      end
    endcase

    if (!err_v && !accept && eof) begin
      err_v = 1'b1;
      err_c = ERR_TRUNCATED;
    end
  end

  // result request, priority: error, accept, header, data
  always_comb begin
    res_o       = '0;
    res_o.valid = !halted_q && (err_v || accept || hdr || data);
    if (err_v) begin
      res_o.item.kind       = KIND_ERROR;
      res_o.item.error_code = err_c;
    end else if (accept) begin
      res_o.item.kind = KIND_ACCEPT;
    end else if (hdr) begin
      res_o.item.kind         = KIND_HEADER;
      res_o.item.image_width  = width_q;
      res_o.item.image_height = height_q;
      res_o.item.sample_depth = depth_q;
      res_o.item.color_type   = color_q[2:0];
    end else begin
      res_o.item.kind      = KIND_DATA;
      res_o.item.data_byte = b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SIG;
      count_q    <= '0;
      len_q      <= '0;
      type_q     <= '0;
      crc_q      <= CRC_PRESET;
      stored_q   <= '0;
      hdr_seen_q <= 1'b0;
      pay_seen_q <= 1'b0;
      width_q    <= '0;
      height_q   <= '0;
      depth_q    <= '0;
      color_q    <= '0;
      halted_q   <= 1'b0;
    end else if (fire_i && !halted_q) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      len_q      <= len_d;
      type_q     <= type_d;
      crc_q      <= crc_d;
      stored_q   <= stored_d;
      hdr_seen_q <= hdr_seen_d;
      pay_seen_q <= pay_seen_d;
      width_q    <= width_d;
      height_q   <= height_d;
      depth_q    <= depth_d;
      color_q    <= color_d;
      halted_q   <= err_v || accept;
    end
  end

endmodule

>>> hw/rtl/pngc_out_stage.sv
// Output register: holds one result while the receiver stalls.
// Depends on pngc_pkg.
`timescale 1ns / 1ps

module pngc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  pngc_pkg::pngc_res_t res_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output pngc_pkg::pngc_out_t out_data_o,
  output logic                full_stall_o
);
  import pngc_pkg::*;

  logic      valid_q;
  pngc_out_t item_q;

  // input side may load whenever the slot is empty or draining this cycle
  assign full_stall_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_i.valid;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      item_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;

endmodule
